[src/gvm_pkg.sv]
// Package for the GF(2^8) vector-matrix multiply-accumulate block.
// Holds field widths, opcodes, the lane-to-merge control struct and the byte multiplier.
// No dependencies.
`timescale 1ns / 1ps

package gvm_pkg;

    localparam int LANES        = 8;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = LANES * BYTE_W;
    localparam int IDX_W        = 4;
    localparam int DEF_ACC_WORDS = 16;

    // Field polynomial x^8+x^4+x^3+x+1 and the nibble split mask.
    localparam logic [8:0] GF_POLY     = 9'h11B;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_MAC  = 1'b1
    } op_t;

    // Control handed from the pipeline register to the merge stage.
    typedef struct packed
    {
        op_t  op;
        logic in_range;
        logic fwd;
        logic rd_vld;
    } merge_ctrl_t;

    // Carry-less product of two bytes, reduced modulo GF_POLY.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ (15'(a) << i);
        end
        for (int j = 14; j >= 8; j--)
        begin
            if (p[j])
                p = p ^ (15'(GF_POLY) << (j - 8));
        end
        return p[7:0];
    endfunction

endpackage

[src/gvm_lane.sv]
// One byte lane: multiplies a data byte by the row coefficient in GF(2^8).
// Depends on gvm_pkg.
`timescale 1ns / 1ps

module gvm_lane
(
    input  logic [gvm_pkg::BYTE_W-1:0] coef,
    input  logic [gvm_pkg::BYTE_W-1:0] data_byte,
    output logic [gvm_pkg::BYTE_W-1:0] prod
);

    logic [3:0] lo_nib;
    logic [3:0] hi_nib;

    // Form the product from the low and high nibble halves and sum them.
    assign lo_nib = data_byte[3:0] & gvm_pkg::NIBBLE_MASK;
    assign hi_nib = data_byte[7:4] & gvm_pkg::NIBBLE_MASK;
    assign prod   = gvm_pkg::gf_mul(coef, {4'b0000, lo_nib})
                  ^ gvm_pkg::gf_mul(coef, {hi_nib, 4'b0000});

endmodule

[src/gvm_merge.sv]
// Merge stage: combines the lane products with the old accumulator word.
// Depends on gvm_pkg.
`timescale 1ns / 1ps

module gvm_merge
(
    input  gvm_pkg::merge_ctrl_t        ctrl,
    input  logic [gvm_pkg::WORD_W-1:0]  mem_word,
    input  logic [gvm_pkg::WORD_W-1:0]  fwd_word,
    input  logic [gvm_pkg::WORD_W-1:0]  prod_word,
    input  logic [gvm_pkg::WORD_W-1:0]  data_word,
    output logic [gvm_pkg::WORD_W-1:0]  new_word,
    output logic [gvm_pkg::WORD_W-1:0]  result_word
);

    logic [gvm_pkg::WORD_W-1:0] old_word;

    always_comb
    begin
        // Never-written entries read as zero; a write at the read edge wins.
        if (ctrl.fwd)
            old_word = fwd_word;
        else if (ctrl.rd_vld)
            old_word = mem_word;
        else
            old_word = '0;

        case (ctrl.op)
            gvm_pkg::OP_LOAD: new_word = data_word;
            gvm_pkg::OP_MAC:  new_word = old_word ^ prod_word;
            default:          new_word = data_word;
        endcase

        result_word = ctrl.in_range ? new_word : '0;
    end

endmodule

[src/gf256_vector_matrix_muladd.sv]
// GF(2^8) vector-matrix multiply-accumulate, polynomial 0x11B: top level.
// Instantiates gvm_lane (eight byte lanes) and gvm_merge; uses gvm_pkg.
`timescale 1ns / 1ps

// Each input beat either loads one 64-bit accumulator word (opcode 0) or XORs
// into it the word's eight bytes times the coefficient (opcode 1); every beat
// returns one result beat with the updated word, its index and the echoed
// final mark. Unless the output stalls, the block takes one beat per cycle
// back to back; a beat passes stage 1 and the output register. The rate is set
// by the accumulator memory: one registered read at acceptance and one write
// per cycle, with a bypass so that consecutive beats on the same word chain
// correctly. A word_index at or beyond ACC_WORDS changes nothing and returns
// a zero word. All words read as zero after reset (per-word valid flags), so
// no clearing pass is needed; final_mark does not clear the accumulator.
module gf256_vector_matrix_muladd
#(
    parameter int ACC_WORDS = gvm_pkg::DEF_ACC_WORDS
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [gvm_pkg::IDX_W-1:0]   word_index,
    input  logic [gvm_pkg::BYTE_W-1:0]  coefficient,
    input  logic [gvm_pkg::WORD_W-1:0]  data_word,
    input  logic                        final_mark,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gvm_pkg::IDX_W-1:0]   out_index,
    output logic [gvm_pkg::WORD_W-1:0]  acc_word,
    output logic                        final_out
);

    localparam int ADDR_W = (ACC_WORDS > 1) ? $clog2(ACC_WORDS) : 1;

    // Accumulator memory and its per-word valid flags.
    logic [gvm_pkg::WORD_W-1:0] mem [ACC_WORDS];
    logic [ACC_WORDS-1:0]       vld_reg;

    // Stage 1: accepted beat, lane products and memory read data.
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    gvm_pkg::op_t                s1_op_reg;
    logic [gvm_pkg::IDX_W-1:0]   s1_idx_reg;
    logic                        s1_fin_reg;
    logic [gvm_pkg::WORD_W-1:0]  s1_data_reg;
    logic [gvm_pkg::WORD_W-1:0]  s1_prod_reg;
    logic                        s1_in_range_reg;
    logic                        s1_fwd_reg;
    logic                        s1_rd_vld_reg;
    logic [gvm_pkg::WORD_W-1:0]  rd_word_reg;
    logic [gvm_pkg::WORD_W-1:0]  fwd_word_reg;

    // Output register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [gvm_pkg::IDX_W-1:0]   out_index_reg;
    logic [gvm_pkg::WORD_W-1:0]  out_word_reg;
    logic                        out_final_reg;

    logic                        accept;
    logic                        s1_adv;
    logic                        in_range;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        wr_en;
    logic [gvm_pkg::WORD_W-1:0]  prod_word;
    logic [gvm_pkg::WORD_W-1:0]  new_word;
    logic [gvm_pkg::WORD_W-1:0]  result_word;
    gvm_pkg::merge_ctrl_t        mctrl;

    // Handshake: stage 1 drains into the output register whenever it is free
    // or being emptied; the input stalls only while stage 1 is held.
    assign s1_adv         = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !s1_adv;
    assign accept         = in_valid && !in_stall;
    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    assign in_range = (int'(word_index) < ACC_WORDS);
    assign rd_addr  = ADDR_W'(word_index);
    assign wr_addr  = ADDR_W'(s1_idx_reg);
    assign wr_en    = s1_adv && s1_in_range_reg;

    // Eight byte lanes work on the incoming beat in parallel.
    for (genvar g = 0; g < gvm_pkg::LANES; g++)
    begin : g_lane
        gvm_lane u_lane
        (
            .coef      (coefficient),
            .data_byte (data_word[g*gvm_pkg::BYTE_W +: gvm_pkg::BYTE_W]),
            .prod      (prod_word[g*gvm_pkg::BYTE_W +: gvm_pkg::BYTE_W])
        );
    end

    assign mctrl.op       = s1_op_reg;
    assign mctrl.in_range = s1_in_range_reg;
    assign mctrl.fwd      = s1_fwd_reg;
    assign mctrl.rd_vld   = s1_rd_vld_reg;

    gvm_merge u_merge
    (
        .ctrl        (mctrl),
        .mem_word    (rd_word_reg),
        .fwd_word    (fwd_word_reg),
        .prod_word   (s1_prod_reg),
        .data_word   (s1_data_reg),
        .new_word    (new_word),
        .result_word (result_word)
    );

    // Memory: write the updated word as its beat leaves stage 1, read at acceptance.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= new_word;
        if (accept)
            rd_word_reg <= mem[rd_addr];
    end

    // Valid flags and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload: capture the beat and its products; flag a same-word
    // write at this edge so the merge takes the bypass instead of stale data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= gvm_pkg::op_t'(opcode);
            s1_idx_reg      <= word_index;
            s1_fin_reg      <= final_mark;
            s1_data_reg     <= data_word;
            s1_prod_reg     <= prod_word;
            s1_in_range_reg <= in_range;
            s1_rd_vld_reg   <= in_range && vld_reg[rd_addr];
            s1_fwd_reg      <= wr_en && in_range && (s1_idx_reg == word_index);
            fwd_word_reg    <= new_word;
        end
    end

    // Output payload: advance on a stage 1 drain, hold while stalled.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_index_reg <= s1_idx_reg;
            out_word_reg  <= result_word;
            out_final_reg <= s1_fin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign acc_word  = out_word_reg;
    assign final_out = out_final_reg;

    // A beat outside the store must come out with a zero word.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (int'(out_index) >= ACC_WORDS) |-> acc_word == '0)
        else $error("out-of-range beat returned a nonzero word");

    // A load of a valid word returns exactly the loaded data.
    a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_in_range_reg && (s1_op_reg == gvm_pkg::OP_LOAD)
        |=> acc_word == $past(s1_data_reg))
        else $error("load beat did not return its data");

    // The input stalls only while both stages are occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // A drained stage 1 beat always lands in the output register.
    a_drain_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid)
        else $error("stage 1 beat lost on the way to the output");

endmodule
